// ===== rtl/first_occurrence_substring_search_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the first-occurrence substring search block
// Shared concurrent check forms, all clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef FIRST_OCCURRENCE_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define FIRST_OCCURRENCE_SUBSTRING_SEARCH_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define FOS_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define FOS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FOS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fos_pkg.sv =====
// ---------------------------------------------------------------------------
// fos_pkg
// Shared types, codes and defaults of the first-occurrence substring search.
// ---------------------------------------------------------------------------
`default_nettype none

package fos_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_PATTERN = 16;
  localparam longint unsigned DEF_MAX_TEXT = 64'd65536;
  localparam int DEF_ELEMENT_BITS = 8;

  // Fixed field widths of the stream interface
  localparam int ELEM_FIELD_W = 8;
  localparam int STATUS_W = 2;
  localparam int INDEX_W = 16;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd2;

  // Classified operation of one input beat
  typedef enum logic [1:0] {
    CMD_PAT,
    CMD_PAT_LAST,
    CMD_TEXT,
    CMD_TEXT_LAST
  } cmd_t;

  typedef struct packed {
    cmd_t                    op;
    logic [ELEM_FIELD_W-1:0] element;
  } item_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fos_front.sv =====
// ---------------------------------------------------------------------------
// fos_front
// Input stage: accepts stream beats, classifies them and masks the element.
// ---------------------------------------------------------------------------
`default_nettype none

module fos_front #(
  parameter int ELEMENT_BITS = fos_pkg::DEF_ELEMENT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fos_pkg::ELEM_FIELD_W-1:0]  s_tdata,  // [7:0] element
  input  logic                              s_tuser,  // [0] kind
  input  logic                              s_tlast,
  output logic                              push,
  output fos_pkg::item_t                    push_item,
  input  logic                              q_full
);
  import fos_pkg::*;

  localparam int EW = (ELEMENT_BITS < ELEM_FIELD_W) ? ELEMENT_BITS : ELEM_FIELD_W;
  localparam logic [ELEM_FIELD_W:0] ONE_EXT = (ELEM_FIELD_W+1)'(1);
  localparam logic [ELEM_FIELD_W-1:0] ELEM_MASK =
    ELEM_FIELD_W'((ONE_EXT << EW) - ONE_EXT);

  logic  hold_valid;
  item_t hold_item;
  cmd_t  op_in;

  // Classify kind and last into one operation code
  always_comb begin
    case ({s_tuser, s_tlast})
      2'b00:   op_in = CMD_PAT;
      2'b01:   op_in = CMD_PAT_LAST;
      2'b10:   op_in = CMD_TEXT;
      default: op_in = CMD_TEXT_LAST;
    endcase
  end

  assign s_tready  = !hold_valid || !q_full;
  assign push      = hold_valid && !q_full;
  assign push_item = hold_item;

  // Hold one classified beat until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
    end else if (!q_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_item.op      <= op_in;
      hold_item.element <= s_tdata & ELEM_MASK;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fos_queue.sv =====
// ---------------------------------------------------------------------------
// fos_queue
// Short command queue that decouples the input stage from the search engine.
// ---------------------------------------------------------------------------
`default_nettype none

module fos_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fos_pkg::item_t      push_item,
  input  logic                pop,
  output fos_pkg::item_t      pop_item,
  output fos_pkg::q_stat_t    stat
);
  import fos_pkg::*;

  item_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign stat.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;
  assign pop_item   = mem[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QUEUE_PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QUEUE_PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QUEUE_CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QUEUE_CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fos_back.sv =====
// ---------------------------------------------------------------------------
// fos_back
// Search engine: pattern register, text window, parallel compare, result.
// ---------------------------------------------------------------------------
`default_nettype none

module fos_back #(
  parameter int              MAX_PATTERN  = fos_pkg::DEF_MAX_PATTERN,
  parameter longint unsigned MAX_TEXT     = fos_pkg::DEF_MAX_TEXT,
  parameter int              ELEMENT_BITS = fos_pkg::DEF_ELEMENT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  fos_pkg::item_t                q_item,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fos_pkg::STATUS_W-1:0]  res_status,
  output logic [fos_pkg::INDEX_W-1:0]   res_index
);
  import fos_pkg::*;

  localparam int EW    = (ELEMENT_BITS < ELEM_FIELD_W) ? ELEMENT_BITS : ELEM_FIELD_W;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = $clog2(MAX_TEXT + 1);
  localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

  logic [EW-1:0]    pat     [MAX_PATTERN];
  logic [EW-1:0]    win     [MAX_PATTERN];
  logic [EW-1:0]    win_next[MAX_PATTERN];
  logic [LEN_W-1:0] pat_len;
  logic             pat_closed;
  logic [POS_W-1:0] pos;
  logic             seen;
  logic [POS_W-1:0] first;

  logic             go;
  logic             is_pat;
  logic             is_last;
  logic [EW-1:0]    elem;
  logic [MAX_PATTERN-1:0] eq;
  logic             advance;
  logic [POS_W-1:0] pos_next;
  logic             long_enough;
  logic             hit;
  logic             pat_shift;
  logic [LEN_W-1:0] pat_len_next;
  logic [POS_W+INDEX_W-1:0] first_ext;

  assign go      = !q_empty && (!m_tvalid || m_tready);
  assign pop     = go;
  assign is_pat  = (q_item.op == CMD_PAT) || (q_item.op == CMD_PAT_LAST);
  assign is_last = (q_item.op == CMD_PAT_LAST) || (q_item.op == CMD_TEXT_LAST);
  assign elem    = q_item.element[EW-1:0];

  // Window after taking this element, newest at entry 0
  always_comb begin
    win_next[0] = elem;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_next[i] = win[i-1];
    end
  end

  // Compare every window entry with its pattern entry in parallel
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq[i] = (LEN_W'(i) >= pat_len) || (win_next[i] == pat[i]);
    end
  end

  assign advance     = (pos < POS_W'(MAX_TEXT));
  assign pos_next    = advance ? POS_W'(pos + 1'b1) : pos;
  assign long_enough = (CMP_W'(pos_next) >= CMP_W'(pat_len));
  assign hit         = advance && !seen && long_enough && (&eq);

  // Pattern load: restart after a closed pattern, saturate at full depth
  assign pat_shift    = pat_closed || (pat_len < LEN_W'(MAX_PATTERN));
  assign pat_len_next = pat_closed ? LEN_W'(1)
                      : (pat_shift ? LEN_W'(pat_len + 1'b1) : pat_len);

  always_ff @(posedge clk) begin
    if (go && is_pat && pat_shift) begin
      pat[0] <= elem;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        pat[i] <= pat[i-1];
      end
    end
  end

  // Pattern and text state
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len    <= '0;
      pat_closed <= 1'b0;
      pos        <= '0;
      seen       <= 1'b0;
      first      <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win[i] <= '0;
      end
    end else if (go) begin
      if (is_pat || is_last) begin
        pos   <= '0;
        seen  <= 1'b0;
        first <= '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win[i] <= '0;
        end
      end else if (advance) begin
        pos <= pos_next;
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win[i] <= win_next[i];
        end
        if (hit) begin
          seen  <= 1'b1;
          first <= POS_W'(pos_next - POS_W'(pat_len));
        end
      end
      if (is_pat) begin
        pat_len    <= pat_len_next;
        pat_closed <= is_last;
      end else begin
        pat_closed <= 1'b1;
      end
    end
  end

  assign first_ext = (POS_W+INDEX_W)'(hit ? POS_W'(pos_next - POS_W'(pat_len)) : first);

  // Result register, loaded on the final text beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && !is_pat && is_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && !is_pat && is_last) begin
      if (!long_enough) begin
        res_status <= ST_SHORT;
        res_index  <= '0;
      end else if (seen || hit) begin
        res_status <= ST_FOUND;
        res_index  <= first_ext[INDEX_W-1:0];
      end else begin
        res_status <= ST_NOT_FOUND;
        res_index  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/first_occurrence_substring_search_top.sv =====
// ---------------------------------------------------------------------------
// first_occurrence_substring_search_top
// Finds the first text index at which a loaded pattern occurs.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser = 0 loads a pattern element, tuser = 1 streams a
//   text element; tlast marks the final element of pattern or text. A
//   pattern beat after a closed pattern starts a new one; any pattern beat
//   abandons a search in progress without a result.
//   Master channel: one beat per text run, sent on the text beat with tlast.
//   tdata carries status (found, not found, text shorter than pattern) and
//   the match index; tlast is always high.
//   Throughput: one beat per cycle on the slave side while no result is held.
//   The window compare against the stored pattern is combinational, so the
//   engine takes a beat every cycle unless a held result stops it.
//   Result path: the final text beat passes the input register, the command
//   queue and the engine result register, in that order, to the result beat.
//   Reset: clears pattern length, text state and all valid flags.
//   Stall: a result held by a low m_tready stops the engine; the queue of
//   QUEUE_DEPTH commands then fills and s_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module first_occurrence_substring_search_top #(
  parameter int              MAX_PATTERN  = fos_pkg::DEF_MAX_PATTERN,
  parameter longint unsigned MAX_TEXT     = fos_pkg::DEF_MAX_TEXT,
  parameter int              ELEMENT_BITS = fos_pkg::DEF_ELEMENT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] element
  input  logic        s_tuser,   // [0] kind
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] status, [17:2] match_index, zero fill
  output logic        m_tlast
);
  import fos_pkg::*;

  `include "first_occurrence_substring_search_top_defines.svh"

  logic                push;
  item_t               push_item;
  logic                pop;
  item_t               pop_item;
  q_stat_t             q_stat;
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_index;

  fos_front #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_stat.full)
  );

  fos_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  fos_back #(
    .MAX_PATTERN  (MAX_PATTERN),
    .MAX_TEXT     (MAX_TEXT),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_stat.empty),
    .q_item     (pop_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .res_status (res_status),
    .res_index  (res_index)
  );

  assign m_tdata = {6'b0, res_index, res_status};
  assign m_tlast = 1'b1;

  // Queue fill level agrees with its empty flag
  `FOS_ALWAYS(a_queue_empty, q_stat.empty == (q_stat.count == '0), "queue empty flag mismatch")
  // Queue never holds more than its depth
  `FOS_ALWAYS(a_queue_bound, q_stat.count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue over depth")
  // Only a found result carries a nonzero index
  `FOS_IMPLIES(a_index_zero, m_tvalid && (res_status != ST_FOUND), res_index == '0, "index without match")
  // Engine does not pop while a stalled result is held
  `FOS_IMPLIES(a_no_pop_stall, m_tvalid && !m_tready, !pop, "pop during output stall")

endmodule

`default_nettype wire

// ===== tb/tb_first_occurrence_substring_search_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_first_occurrence_substring_search_top
// Self-checking bench for the first-occurrence substring search block.
// Drives pattern and text beats on the slave stream and predicts every
// search outcome with a cycle-free model of the search. Covers empty and
// overlong patterns, abandoned searches, short texts and open patterns
// closed by text. Both stream sides idle at random.
// ---------------------------------------------------------------------------

module tb_first_occurrence_substring_search_top;

  localparam int          PAT_SLOTS    = fos_pkg::DEF_MAX_PATTERN;
  localparam longint unsigned TEXT_LIMIT = fos_pkg::DEF_MAX_TEXT;
  localparam int          RESET_CYCLES = 12;
  localparam int          LONG_HOLD    = 150;
  localparam int          SETTLE       = 20;
  localparam bit          KIND_PATTERN = 1'b0;
  localparam bit          KIND_TEXT    = 1'b1;

  typedef struct packed {
    logic [fos_pkg::STATUS_W-1:0] status;
    logic [fos_pkg::INDEX_W-1:0]  index;
  } search_outcome_t;

  // Predict search outcomes and compare them with the result beats
  class search_scoreboard;
    search_outcome_t   awaited_outcomes[$];
    logic [7:0]        pattern[PAT_SLOTS];
    logic [7:0]        window[PAT_SLOTS];
    int unsigned       pattern_len;
    longint unsigned   text_count;
    longint unsigned   hit_index;
    bit                hit_seen;
    bit                pattern_done;
    int                errors;
    int                checked;

    function new();
      foreach (pattern[i]) pattern[i] = '0;
      pattern_len  = 0;
      pattern_done = 1'b0;
      errors       = 0;
      checked      = 0;
      clear_search();
    endfunction

    function void clear_search();
      foreach (window[i]) window[i] = '0;
      text_count = 0;
      hit_seen   = 1'b0;
      hit_index  = 0;
    endfunction

    function int pending_count();
      return awaited_outcomes.size();
    endfunction

    // Advance the search state by one accepted input beat
    function void take_element(bit kind, logic [7:0] elem, bit last);
      search_outcome_t outcome;
      bit same;
      if (kind == KIND_PATTERN) begin
        if (pattern_done) begin
          pattern_len  = 0;
          pattern_done = 1'b0;
        end
        if (pattern_len < PAT_SLOTS) begin
          pattern[pattern_len] = elem;
          pattern_len++;
        end
        if (last) pattern_done = 1'b1;
        clear_search();
        return;
      end
      pattern_done = 1'b1;
      // Shift the window unless the text is past its limit
      if (text_count < TEXT_LIMIT) begin
        for (int i = PAT_SLOTS - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = elem;
        text_count++;
        if (!hit_seen && text_count >= pattern_len) begin
          same = 1'b1;
          for (int i = 0; i < pattern_len; i++)
            if (window[i] != pattern[pattern_len-1-i]) same = 1'b0;
          if (same) begin
            hit_seen  = 1'b1;
            hit_index = text_count - pattern_len;
          end
        end
      end
      if (!last) return;
      outcome.index = '0;
      if (text_count < pattern_len) begin
        outcome.status = fos_pkg::ST_SHORT;
      end else if (hit_seen) begin
        outcome.status = fos_pkg::ST_FOUND;
        outcome.index  = hit_index[15:0];
      end else begin
        outcome.status = fos_pkg::ST_NOT_FOUND;
      end
      awaited_outcomes.push_back(outcome);
      clear_search();
    endfunction

    function void flag(string what, logic [31:0] expected, logic [31:0] actual);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expected,
               actual);
    endfunction

    // Compare one result beat with the oldest outcome
    function void check_outcome(logic [23:0] data, logic last_flag);
      search_outcome_t want;
      checked++;
      if (awaited_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual status %0d index %0d",
                 $time, data[1:0], data[17:2]);
        return;
      end
      want = awaited_outcomes.pop_front();
      if (data[1:0] !== want.status) flag("status", want.status, data[1:0]);
      if (data[17:2] !== want.index) flag("match_index", want.index, data[17:2]);
      if (last_flag !== 1'b1) flag("done flag", 1, last_flag);
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] element
  logic        s_tuser  = 1'b0;    // [0] kind
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;            // [1:0] status, [17:2] match_index, zero fill
  logic        m_tlast;

  search_scoreboard sb = new();

  bit         calm         = 1'b0;
  bit         hold_request = 1'b0;
  bit         need_pattern = 1'b1;
  int         gap_odds     = 0;
  int         sink_odds    = 0;
  int         beats_sent   = 0;
  logic [7:0] cur_pattern[$];
  logic [7:0] pat_base;
  int         pat_spread;

  first_occurrence_substring_search_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Offer one beat, with an occasional idle burst ahead of it
  task automatic send_beat(input bit kind, input logic [7:0] elem, input bit last);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= elem;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.take_element(kind, elem, last);
    beats_sent++;
  endtask

  // Drop valid and hold until every outcome has come back
  task automatic pause_sender();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  // One search: maybe a fresh pattern, then a text with a possible planted match
  task automatic random_search();
    logic [7:0] txt[$];
    int flavor;
    int new_len;
    int txt_len;
    int plant_at;
    flavor = $urandom_range(0, 19);
    case ($urandom_range(0, 3))
      0: gap_odds = 0;
      1: gap_odds = 3;
      default: gap_odds = 10;
    endcase
    case ($urandom_range(0, 2))
      0: sink_odds = 0;
      1: sink_odds = 4;
      default: sink_odds = 12;
    endcase
    if (need_pattern || $urandom_range(0, 2) == 0) begin
      pat_base   = 8'($urandom);
      pat_spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 3);
      new_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(PAT_SLOTS + 1, PAT_SLOTS + 4)
                                               : $urandom_range(1, 6);
      cur_pattern.delete();
      repeat (new_len) cur_pattern.push_back(pat_base ^ 8'($urandom_range(0, pat_spread)));
      // Leave the pattern open now and then so the text closes it
      foreach (cur_pattern[i])
        send_beat(KIND_PATTERN, cur_pattern[i], (i == new_len - 1) && (flavor != 0));
      need_pattern = 1'b0;
    end
    txt_len = $urandom_range(1, 24);
    for (int i = 0; i < txt_len; i++)
      txt.push_back(pat_base ^ 8'($urandom_range(0, pat_spread)));
    if ($urandom_range(0, 1) == 1 && txt_len >= cur_pattern.size()) begin
      plant_at = $urandom_range(0, txt_len - cur_pattern.size());
      foreach (cur_pattern[i]) txt[plant_at + i] = cur_pattern[i];
    end
    if (flavor == 1) begin
      // Abandon halfway: the next pattern load cancels this search
      for (int i = 0; i < (txt_len + 1) / 2; i++) send_beat(KIND_TEXT, txt[i], 1'b0);
      need_pattern = 1'b1;
    end else begin
      foreach (txt[i]) send_beat(KIND_TEXT, txt[i], i == txt_len - 1);
    end
  endtask

  // Check every result beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_outcome(m_tdata, m_tlast);
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!calm && sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
        m_tready <= 1'b0;
        stall = $urandom_range(1, 19);
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed corner cases
    gap_odds  = 4;
    sink_odds = 4;
    send_beat(KIND_TEXT, 8'h3C, 1'b1);          // no pattern loaded yet
    send_beat(KIND_PATTERN, 8'h00, 1'b0);
    send_beat(KIND_PATTERN, 8'hFF, 1'b1);
    send_beat(KIND_TEXT, 8'h12, 1'b0);
    send_beat(KIND_TEXT, 8'h00, 1'b0);
    send_beat(KIND_TEXT, 8'hFF, 1'b1);          // match at index one
    send_beat(KIND_TEXT, 8'hFF, 1'b1);          // text shorter than pattern
    send_beat(KIND_TEXT, 8'hAA, 1'b0);
    send_beat(KIND_TEXT, 8'h55, 1'b1);          // no match
    send_beat(KIND_TEXT, 8'h00, 1'b0);
    send_beat(KIND_PATTERN, 8'h5A, 1'b0);       // cancel search, pattern left open
    send_beat(KIND_TEXT, 8'h5A, 1'b1);          // text closes the pattern
    send_beat(KIND_PATTERN, 8'h7F, 1'b0);
    send_beat(KIND_PATTERN, 8'h80, 1'b1);
    send_beat(KIND_TEXT, 8'h7F, 1'b0);
    send_beat(KIND_TEXT, 8'h80, 1'b0);
    send_beat(KIND_TEXT, 8'h7F, 1'b0);
    send_beat(KIND_TEXT, 8'h80, 1'b1);          // two matches, first one counts
    pause_sender();

    // Random searches, first half
    while (beats_sent < 750) random_search();
    pause_sender();

    // Hold the result side while single-beat texts pile up
    gap_odds = 0;
    hold_request = 1'b1;
    repeat (12) send_beat(KIND_TEXT, 8'($urandom), 1'b1);
    pause_sender();

    // Random searches, second half
    while (beats_sent < 1400) random_search();
    pause_sender();

    // Final stretch without idling
    calm = 1'b1;
    while (beats_sent < 1500) random_search();
    pause_sender();
    repeat (SETTLE) @(posedge clk);

    if (sb.pending_count() != 0) begin
      sb.errors++;
      $display("%0t: outcomes left over, expected 0, actual %0d", $time, sb.pending_count());
    end
    $display("Run covered %0d input beats and %0d result beats: corner cases, random",
             beats_sent, sb.checked);
    $display("searches with planted matches, abandoned searches and a long output stall.");
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d outcomes still awaited", sb.pending_count());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fos_pkg.sv
rtl/fos_front.sv
rtl/fos_queue.sv
rtl/fos_back.sv
rtl/first_occurrence_substring_search_top.sv
tb/tb_first_occurrence_substring_search_top.sv
